// File: design/rsip_pkg.sv
package rsip_pkg;

  // widths fixed by the field definitions
  localparam int VALUE_BITS_DEF = 64;
  localparam int OUT_BITS       = 64;
  localparam int RADIX_BITS     = 6;
  localparam int DIGIT_BITS     = 6;
  localparam int CHAR_BITS      = 8;
  localparam int STATUS_BITS    = 2;

  // character codes
  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CHAR_0     = 8'h30;
  localparam logic [CHAR_BITS-1:0] CHAR_9     = 8'h39;
  localparam logic [CHAR_BITS-1:0] CHAR_LA    = 8'h61;
  localparam logic [CHAR_BITS-1:0] CHAR_LZ    = 8'h7A;
  localparam logic [CHAR_BITS-1:0] CHAR_UA    = 8'h41;
  localparam logic [CHAR_BITS-1:0] CHAR_UZ    = 8'h5A;
  localparam logic [CHAR_BITS-1:0] LETTER_BASE = 8'd10;

  // radix limits and reset value
  localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;

  // status codes
  localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_BAD_DIGIT = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_OVERFLOW  = 2'd2;

  typedef struct packed {
    logic [CHAR_BITS-1:0] char_code;
    logic                 is_final;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] value;
    logic [STATUS_BITS-1:0]     status;
  } out_item_t;

  // decoded character, handed from the decoder to the accumulator
  typedef struct packed {
    logic                  is_minus;
    logic                  ok;
    logic [DIGIT_BITS-1:0] digit;
    logic [RADIX_BITS-1:0] radix_eff;
  } digit_info_t;

endpackage

// File: design/rsip_digit.sv
module rsip_digit (
  input  logic [rsip_pkg::CHAR_BITS-1:0]  char_code,
  input  logic                            at_start,
  input  logic [rsip_pkg::RADIX_BITS-1:0] radix,
  output rsip_pkg::digit_info_t           info
);
  import rsip_pkg::*;

  logic                  is_num;
  logic                  is_lower;
  logic                  is_upper;
  logic [CHAR_BITS-1:0]  raw;
  logic [RADIX_BITS-1:0] radix_eff;

  // character class
  assign is_num   = (char_code >= CHAR_0)  && (char_code <= CHAR_9);
  assign is_lower = (char_code >= CHAR_LA) && (char_code <= CHAR_LZ);
  assign is_upper = (char_code >= CHAR_UA) && (char_code <= CHAR_UZ);

  // digit value of the character
  always_comb begin
    priority if (is_num) begin
      raw = char_code - CHAR_0;
    end else if (is_lower) begin
      raw = char_code - CHAR_LA + LETTER_BASE;
    end else begin
      raw = char_code - CHAR_UA + LETTER_BASE;
    end
  end

  // clamp radix into the supported range
  always_comb begin
    priority if (radix < RADIX_MIN) begin
      radix_eff = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      radix_eff = RADIX_MAX;
    end else begin
      radix_eff = radix;
    end
  end

  assign info.is_minus  = at_start && (char_code == CHAR_MINUS);
  assign info.digit     = raw[DIGIT_BITS-1:0];
  assign info.ok        = (is_num || is_lower || is_upper) && (raw[DIGIT_BITS-1:0] < radix_eff);
  assign info.radix_eff = radix_eff;

endmodule

// File: design/rsip_accum.sv
module rsip_accum #(
  parameter int VALUE_BITS = rsip_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic                  is_final,
  input  rsip_pkg::digit_info_t info,
  output logic                  at_start,
  output rsip_pkg::out_item_t   result
);
  import rsip_pkg::*;

  localparam int PW = VALUE_BITS + RADIX_BITS + 1;
  localparam logic [VALUE_BITS-1:0] LIMIT = {1'b1, {(VALUE_BITS-1){1'b0}}};

  logic [VALUE_BITS-1:0]  magnitude;
  logic                   negative;
  logic [STATUS_BITS-1:0] error_code;

  logic [VALUE_BITS-1:0]  magnitude_next;
  logic                   negative_next;
  logic [STATUS_BITS-1:0] error_code_next;

  logic [PW-1:0]          prod;
  logic [PW-1:0]          sum;
  logic                   ovf;
  logic [STATUS_BITS-1:0] status_fin;
  logic [VALUE_BITS-1:0]  value_vb;

  // magnitude * radix + digit, overflow when past the limit
  assign prod = PW'(magnitude) * PW'(info.radix_eff);
  assign sum  = prod + PW'(info.digit);
  assign ovf  = sum > PW'(LIMIT);

  // one character step
  always_comb begin
    magnitude_next  = magnitude;
    negative_next   = negative;
    error_code_next = error_code;
    if (error_code == ST_OK) begin
      priority if (info.is_minus) begin
        negative_next = 1'b1;
      end else if (!info.ok) begin
        error_code_next = ST_BAD_DIGIT;
      end else if (ovf) begin
        error_code_next = ST_OVERFLOW;
      end else begin
        magnitude_next = sum[VALUE_BITS-1:0];
      end
    end
  end

  // end of string: a positive value cannot reach the limit
  always_comb begin
    status_fin = error_code_next;
    if (error_code_next == ST_OK && !negative_next && magnitude_next == LIMIT) begin
      status_fin = ST_OVERFLOW;
    end
  end

  assign value_vb = negative_next ? (~magnitude_next + 1'b1) : magnitude_next;

  assign result.status = status_fin;
  assign result.value  = (status_fin == ST_OK) ? OUT_BITS'($signed(value_vb)) : '0;

  // string state, cleared after the last character
  always_ff @(posedge clk) begin
    if (rst) begin
      magnitude  <= '0;
      negative   <= 1'b0;
      at_start   <= 1'b1;
      error_code <= ST_OK;
    end else if (fire) begin
      if (is_final) begin
        magnitude  <= '0;
        negative   <= 1'b0;
        at_start   <= 1'b1;
        error_code <= ST_OK;
      end else begin
        magnitude  <= magnitude_next;
        negative   <= negative_next;
        at_start   <= 1'b0;
        error_code <= error_code_next;
      end
    end
  end

endmodule

// File: design/radix_string_to_int_parser.sv
// Parses a number string arriving one character per transaction on the input
// channel, the last character marked by is_final, into a signed value with a
// status (ok, invalid digit, overflow). A leading '-' negates the result;
// digits are 0-9, a-z, A-Z checked against the radix register (clamped to
// 2..36, reset 10). The block takes one character per cycle: the character
// is registered, then one 64 by 6 bit multiply-add on the running magnitude
// updates the string state, and the result of a final character is registered
// in the output register. That multiply-add loop on the magnitude sets the
// rate. While a result waits, one more character can still be taken into the
// input register; after that the input stalls until the result is taken. Radix
// writes belong where no character is in flight; one made mid-string applies
// from the next character.
module radix_string_to_int_parser #(
  parameter int VALUE_BITS = rsip_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rsip_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rsip_pkg::out_item_t             out_data,
  input  logic                            cfg_wr_en,
  input  logic [rsip_pkg::RADIX_BITS-1:0] cfg_wr_data
);
  import rsip_pkg::*;

  logic [RADIX_BITS-1:0] radix;
  logic                  s1_valid;
  in_item_t              s1_data;
  logic                  advance;
  logic                  fire;
  logic                  at_start;
  digit_info_t           info;
  out_item_t             result;

  // stage moves when the output register is free or being emptied
  assign advance  = !out_valid || out_ready;
  assign fire     = s1_valid && advance;
  assign in_ready = !s1_valid || advance;

  // radix register
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data <= in_data;
    end
  end

  rsip_digit u_digit (
    .char_code (s1_data.char_code),
    .at_start  (at_start),
    .radix     (radix),
    .info      (info)
  );

  rsip_accum #(
    .VALUE_BITS (VALUE_BITS)
  ) u_accum (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .is_final (s1_data.is_final),
    .info     (info),
    .at_start (at_start),
    .result   (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire && s1_data.is_final;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1_data.is_final) begin
      out_data <= result;
    end
  end

endmodule

// File: design/rsip_checker.sv
module rsip_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input rsip_pkg::in_item_t              in_data,
  input logic                            out_valid,
  input logic                            out_ready,
  input rsip_pkg::out_item_t             out_data
);
  import rsip_pkg::*;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // only the three defined status codes appear
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status == ST_OK || out_data.status == ST_BAD_DIGIT ||
                   out_data.status == ST_OVERFLOW))
    else $error("undefined status code");

  // errored strings report zero
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |-> out_data.value == '0)
    else $error("nonzero value with error status");

  // a fresh result follows an accepted final character
  a_out_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_data.is_final, 2))
    else $error("result without a final character");

  // ready to take a character right after reset
  a_ready_after_rst: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("not ready after reset");

endmodule

bind radix_string_to_int_parser rsip_checker u_rsip_checker (.*);

// File: dv/radix_string_to_int_parser_test.sv
`timescale 1ns / 1ps

module radix_string_to_int_parser_test;
  import rsip_pkg::*;

  localparam int          RANDOM_ITEMS = 850;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          TIMEOUT_NS   = 5_000_000;
  localparam logic [7:0]  NOT_A_DIGIT  = 8'hFF;
  localparam logic [63:0] MAG_LIMIT    = 64'h8000_0000_0000_0000;

  typedef logic [CHAR_BITS-1:0] char_q_t[$];

  // one directed number string, with the result typed in where it is obvious
  typedef struct {
    logic [RADIX_BITS-1:0] radix;
    string                 text;
    logic [CHAR_BITS-1:0]  code;
    int                    switch_at;
    logic [RADIX_BITS-1:0] radix2;
    bit                    known;
    out_item_t             result;
  } string_case_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_wr_en;
  logic [RADIX_BITS-1:0] cfg_wr_data;

  // parser state as the block should hold it
  logic [RADIX_BITS-1:0]  radix_reg;
  logic [63:0]            run_mag;
  logic                   run_neg;
  logic                   run_first;
  logic [STATUS_BITS-1:0] run_err;
  out_item_t              expected_q[$];

  bit        use_typed;
  out_item_t typed_result;
  bit        hold_req;
  bit        held_off;
  int        burst_left;
  int        sent_items;
  int        strings_sent;
  int        radix_writes;
  int        results_seen;
  int        mismatches;
  int        status_count[4];

  string_case_t cases[14];

  radix_string_to_int_parser dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic [RADIX_BITS-1:0] clamp_radix(input logic [RADIX_BITS-1:0] r);
    if (r < RADIX_MIN) return RADIX_MIN;
    if (r > RADIX_MAX) return RADIX_MAX;
    return r;
  endfunction

  // anything outside 0-9, a-z, A-Z maps to a value no radix accepts
  function automatic logic [7:0] digit_value(input logic [CHAR_BITS-1:0] c);
    if (c >= CHAR_0 && c <= CHAR_9) return c - CHAR_0;
    if (c >= CHAR_LA && c <= CHAR_LZ) return c - CHAR_LA + LETTER_BASE;
    if (c >= CHAR_UA && c <= CHAR_UZ) return c - CHAR_UA + LETTER_BASE;
    return NOT_A_DIGIT;
  endfunction

  function automatic void clear_parse();
    run_mag   = '0;
    run_neg   = 1'b0;
    run_first = 1'b1;
    run_err   = ST_OK;
  endfunction

  // advance the parse by one character, returns 1 when a result is due
  function automatic bit parse_char(input in_item_t it, output out_item_t res);
    logic [63:0] r;
    logic [63:0] d;
    res = '0;
    if (run_err == ST_OK) begin
      if (run_first && it.char_code == CHAR_MINUS) begin
        run_neg = 1'b1;
      end else begin
        r = 64'(clamp_radix(radix_reg));
        d = 64'(digit_value(it.char_code));
        if (d >= r) run_err = ST_BAD_DIGIT;
        else if (run_mag > (MAG_LIMIT - d) / r) run_err = ST_OVERFLOW;
        else run_mag = run_mag * r + d;
      end
    end
    run_first = 1'b0;
    if (!it.is_final) return 1'b0;
    // only a negative number may reach the limit itself
    if (run_err == ST_OK && !run_neg && run_mag == MAG_LIMIT) run_err = ST_OVERFLOW;
    if (run_err == ST_OK) res.value = run_neg ? -run_mag : run_mag;
    res.status = run_err;
    clear_parse();
    return 1'b1;
  endfunction

  function automatic logic [CHAR_BITS-1:0] digit_char(input int unsigned d);
    if (d < 10) return CHAR_0 + 8'(d);
    return ($urandom_range(1) ? CHAR_LA : CHAR_UA) + 8'(d) - LETTER_BASE;
  endfunction

  function automatic char_q_t radix_text(input logic [63:0] mag, input int unsigned r);
    char_q_t     text;
    logic [63:0] m;
    m = mag;
    do begin
      text.push_front(digit_char(int'(m % r)));
      m = m / r;
    end while (m != 0);
    return text;
  endfunction

  function automatic logic [RADIX_BITS-1:0] pick_radix();
    case ($urandom_range(7))
      0: return RADIX_MIN;
      1: return RADIX_MAX;
      2: return RADIX_BITS'($urandom_range(1));
      3: return RADIX_BITS'($urandom_range(37, 63));
      default: return RADIX_BITS'($urandom_range(RADIX_MIN, RADIX_MAX));
    endcase
  endfunction

  // mostly well-formed numbers, some near the 64-bit limit, the rest noise
  function automatic char_q_t random_string();
    char_q_t     text;
    int unsigned r;
    int unsigned kind;
    int unsigned len;
    logic [63:0] mag;
    r    = 32'(clamp_radix(radix_reg));
    kind = $urandom_range(99);
    if (kind < 55) begin
      len = $urandom_range(1, 8);
      repeat (len) text.push_back(digit_char($urandom_range(r - 1)));
      if ($urandom_range(3) == 0) text.push_front(CHAR_MINUS);
    end else if (kind < 75) begin
      case ($urandom_range(5))
        0: mag = MAG_LIMIT - 1;
        1: mag = MAG_LIMIT;
        2: mag = MAG_LIMIT - $urandom_range(64);
        3: mag = MAG_LIMIT + $urandom_range(64);
        4: mag = '1;
        default: mag = {$urandom, $urandom} >> $urandom_range(63);
      endcase
      text = radix_text(mag, r);
      if ($urandom_range(3) == 0) text.push_back(digit_char($urandom_range(r - 1)));
      if ($urandom_range(1)) text.push_front(CHAR_MINUS);
    end else if (kind < 90) begin
      len = $urandom_range(1, 6);
      repeat (len) begin
        case ($urandom_range(3))
          0: text.push_back(CHAR_MINUS);
          1: text.push_back(digit_char($urandom_range(r - 1)));
          default: text.push_back(CHAR_BITS'($urandom_range(255)));
        endcase
      end
    end else begin
      // lone minus, digit equal to the radix, digit followed by a minus, or codes just outside the ranges
      case ($urandom_range(3))
        0: text.push_back(CHAR_MINUS);
        1: text.push_back(digit_char(r));
        2: begin
          text.push_back(digit_char($urandom_range(r - 1)));
          text.push_back(CHAR_MINUS);
        end
        default: begin
          case ($urandom_range(5))
            0: text.push_back(CHAR_0 - 8'd1);
            1: text.push_back(CHAR_9 + 8'd1);
            2: text.push_back(CHAR_UA - 8'd1);
            3: text.push_back(CHAR_UZ + 8'd1);
            4: text.push_back(CHAR_LA - 8'd1);
            default: text.push_back(CHAR_LZ + 8'd1);
          endcase
        end
      endcase
    end
    return text;
  endfunction

  task automatic note_failure(input string what, input out_item_t want, input out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at %0t: %s, expected value %0d status %0d, got value %0d status %0d",
               $time, what, want.value, want.status, got.value, got.status);
  endtask

  // idle the sender between bursts of random length
  task automatic pace();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // offer one character and predict its result once the transaction completes
  task automatic push_char(input logic [CHAR_BITS-1:0] code, input logic last);
    in_item_t  it;
    out_item_t res;
    it.char_code = code;
    it.is_final  = last;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sent_items++;
    if (parse_char(it, res)) expected_q.push_back(use_typed ? typed_result : res);
    pace();
  endtask

  // wait until every result is back and the pipeline has emptied
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_radix(input logic [RADIX_BITS-1:0] r);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= r;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    radix_reg = r;
    radix_writes++;
  endtask

  task automatic send_text(input char_q_t text, input int switch_at = -1,
                           input logic [RADIX_BITS-1:0] later_radix = RADIX_RESET);
    foreach (text[k]) begin
      if (k == switch_at) write_radix(later_radix);
      push_char(text[k], k == text.size() - 1);
    end
    strings_sent++;
  endtask

  // compare each result against the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      status_count[out_data.status]++;
      if (expected_q.size() == 0) begin
        note_failure("result with no string pending", '0, out_data);
      end else begin
        want = expected_q.pop_front();
        if (out_data.value !== want.value) note_failure("value", want, out_data);
        if (out_data.status !== want.status) note_failure("status", want, out_data);
      end
    end
  end

  // receiver: stall patterns in stretches, plus one long hold-off on request
  initial begin
    int stretch;
    int mode;
    int tick;
    out_ready <= 1'b0;
    stretch = 0;
    tick    = 0;
    mode    = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        held_off = 1'b1;
      end
      if (stretch == 0) begin
        mode    = $urandom_range(3);
        stretch = $urandom_range(8, 64);
      end
      stretch--;
      tick++;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(1));
        2: out_ready <= (tick % 5) != 0;
        default: out_ready <= ($urandom_range(5) == 0);
      endcase
      @(posedge clk);
    end
  end

  // hard stop in case the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

  // stimulus: directed strings, then random phases with a new radix each
  initial begin
    char_q_t text;
    int      stim_end;
    int      phase;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    radix_reg   = RADIX_RESET;
    clear_parse();
    burst_left  = 1;

    cases = '{
      '{RADIX_RESET, "0", 8'h00, -1, '0, 1'b1, '{64'sd0, ST_OK}},
      '{RADIX_RESET, "-", 8'h00, -1, '0, 1'b1, '{64'sd0, ST_OK}},
      '{RADIX_RESET, "-5", 8'h00, -1, '0, 1'b1, '{-64'sd5, ST_OK}},
      '{RADIX_RESET, "5-", 8'h00, -1, '0, 1'b1, '{64'sd0, ST_BAD_DIGIT}},
      '{RADIX_RESET, "", 8'h00, -1, '0, 1'b1, '{64'sd0, ST_BAD_DIGIT}},
      '{RADIX_RESET, "", 8'hFF, -1, '0, 1'b1, '{64'sd0, ST_BAD_DIGIT}},
      '{RADIX_RESET, "x9", 8'h00, -1, '0, 1'b1, '{64'sd0, ST_BAD_DIGIT}},
      '{RADIX_MAX, "zZ", 8'h00, -1, '0, 1'b0, '{64'sd0, ST_OK}},
      '{RADIX_MIN, "2", 8'h00, -1, '0, 1'b1, '{64'sd0, ST_BAD_DIGIT}},
      '{6'd0, "11", 8'h00, -1, '0, 1'b0, '{64'sd0, ST_OK}},
      '{6'd63, "z", 8'h00, -1, '0, 1'b0, '{64'sd0, ST_OK}},
      '{RADIX_MAX, "-1y2p0ij32e8e8", 8'h00, -1, '0, 1'b0, '{64'sd0, ST_OK}},
      '{RADIX_MAX, "1y2p0ij32e8e8", 8'h00, -1, '0, 1'b0, '{64'sd0, ST_OK}},
      '{RADIX_RESET, "1f", 8'h00, 1, 6'd16, 1'b0, '{64'sd0, ST_OK}}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed strings: extremes, sign handling, clamped radix, mid-string radix change
    foreach (cases[i]) begin
      if (cases[i].radix != radix_reg) write_radix(cases[i].radix);
      text.delete();
      if (cases[i].text.len() == 0) begin
        text.push_back(cases[i].code);
      end else begin
        for (int k = 0; k < cases[i].text.len(); k++) text.push_back(cases[i].text[k]);
      end
      use_typed    = cases[i].known;
      typed_result = cases[i].result;
      send_text(text, cases[i].switch_at, cases[i].radix2);
      use_typed = 1'b0;
    end

    // random phases; the second one runs under a long receiver hold-off
    stim_end = sent_items + RANDOM_ITEMS;
    phase    = 0;
    while (sent_items < stim_end) begin
      write_radix(pick_radix());
      if (phase == 1) hold_req = 1'b1;
      repeat ($urandom_range(6, 16)) send_text(random_string());
      phase++;
    end

    settle();
    $display("run covered %0d characters in %0d strings over %0d radix settings",
             sent_items, strings_sent, radix_writes + 1);
    $display("%0d results: %0d ok, %0d invalid digit, %0d overflow; long hold-off %s",
             results_seen, status_count[ST_OK], status_count[ST_BAD_DIGIT],
             status_count[ST_OVERFLOW], held_off ? "seen" : "missed");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: radix_string_to_int_parser.f
design/rsip_pkg.sv
design/rsip_digit.sv
design/rsip_accum.sv
design/radix_string_to_int_parser.sv
design/rsip_checker.sv
dv/radix_string_to_int_parser_test.sv
